// ----- design/rrss_pkg.sv -----
`default_nettype none

package rrss_pkg;

   localparam int DEFAULT_MAX_TASKS = 8;

   localparam int ACTION_W   = 2;
   localparam int TASK_IDX_W = 3;
   localparam int SLICE_W    = 16;
   localparam int TCOUNT_W   = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEFINE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TASK_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAIN_SLICE = 4'd1;

   localparam logic [TCOUNT_W-1:0] RESET_TASK_COUNT = 4'd1;
   localparam logic [SLICE_W-1:0]  RESET_MAIN_SLICE = 16'd100;
   localparam logic [SLICE_W-1:0]  RESET_SLICE_ZERO = 16'd100;
   localparam logic [SLICE_W-1:0]  RESET_SLICE_REST = 16'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REDUCE,
      ST_SEARCH,
      ST_READ,
      ST_LOAD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                expires;
      logic                cand_ge_n;
      logic                cand_active;
      logic                search_last;
      logic                out_free;
   } status_type;

   typedef struct packed {
      logic accept;
      logic do_define;
      logic do_restart;
      logic do_tick_dec;
      logic start_search;
      logic reduce_step;
      logic search_adv;
      logic take_cand;
      logic take_zero;
      logic mem_read;
      logic load_slice;
      logic emit;
   } ctrl_type;

   function automatic logic [SLICE_W-1:0] nonzero_slice(input logic [SLICE_W-1:0] value);
      return (value == '0) ? {{(SLICE_W-1){1'b0}}, 1'b1} : value;
   endfunction

endpackage

`default_nettype wire

// ----- design/rrss_if.sv -----
`default_nettype none

interface rrss_req_if import rrss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [TASK_IDX_W-1:0] task_index;
   logic [SLICE_W-1:0]    slice_ticks;

   modport source (output valid, action, task_index, slice_ticks, input ready);
   modport sink (input valid, action, task_index, slice_ticks, output ready);
endinterface

interface rrss_rsp_if import rrss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  switched;
   logic [TASK_IDX_W-1:0] running_task;
   logic [SLICE_W-1:0]    ticks_left;

   modport source (output valid, switched, running_task, ticks_left, input ready);
   modport sink (input valid, switched, running_task, ticks_left, output ready);
endinterface

interface rrss_csr_if import rrss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/round_robin_slice_scheduler.sv -----
// A tick that does not end a slice, a define beat and a restart beat go from decode to finish.
// A tick that ends a slice goes through decode, reduce (modulo subtractions, none unless the
// current task is the last one in the rotation or lies outside it), search, which probes at most
// rotation size slots, read, load and finish. In finish the result is registered once the output
// is free, and a new beat is accepted in the cycle after the result is registered.
// Synchronous active-high reset restores control and CSR state and marks all table entries invalid.
`default_nettype none

module round_robin_slice_scheduler import rrss_pkg::*; #(
   parameter int MAX_TASKS = DEFAULT_MAX_TASKS
) (
   input wire logic  clock,
   input wire logic  reset,
   rrss_req_if.sink  req_ch,
   rrss_rsp_if.source rsp_ch,
   rrss_csr_if.sink  csr_ch
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   logic [TCOUNT_W-1:0]   task_count_ff;
   logic [SLICE_W-1:0]    main_slice_ff;
   logic [ACTION_W-1:0]   action_ff;
   logic [TASK_IDX_W-1:0] index_ff;
   logic [SLICE_W-1:0]    slice_ff;
   logic [IDX_W-1:0]      cur_ff;
   logic [SLICE_W-1:0]    remain_ff;
   logic [CNT_W-1:0]      cand_ff;
   logic [CNT_W-1:0]      cand_in;
   logic [CNT_W-1:0]      step_ff;
   logic [IDX_W-1:0]      next_ff;
   logic                  sw_ff;
   logic [MAX_TASKS-1:0]  active_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_switched_ff;
   logic [TASK_IDX_W-1:0] rsp_task_ff;
   logic [SLICE_W-1:0]    rsp_ticks_ff;

   logic [CNT_W-1:0]   rot_n;
   logic [CNT_W-1:0]   cand_inc;
   logic               define_ok;
   logic [SLICE_W-1:0] restart_slice;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [SLICE_W-1:0] mem_wr_data;
   logic [SLICE_W-1:0] mem_rd_data;
   status_type         status;
   ctrl_type           ctrl;
   logic               req_ready;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= RESET_TASK_COUNT;
         main_slice_ff <= RESET_MAIN_SLICE;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_TASK_COUNT: task_count_ff <= csr_ch.data[TCOUNT_W-1:0];
            REG_MAIN_SLICE: main_slice_ff <= csr_ch.data[SLICE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (task_count_ff == '0) begin
         rot_n = CNT_W'(1);
      end else if (32'(task_count_ff) > MAX_TASKS) begin
         rot_n = CNT_W'(MAX_TASKS);
      end else begin
         rot_n = CNT_W'(task_count_ff);
      end
   end

   assign define_ok     = (32'(index_ff) < MAX_TASKS);
   assign restart_slice = nonzero_slice(main_slice_ff);
   assign cand_inc      = cand_ff + CNT_W'(1);

   assign status.action      = action_ff;
   assign status.expires     = (remain_ff <= SLICE_W'(1));
   assign status.cand_ge_n   = (cand_ff >= rot_n);
   assign status.cand_active = active_ff[cand_ff[IDX_W-1:0]];
   assign status.search_last = (step_ff == rot_n);
   assign status.out_free    = !rsp_valid_ff || rsp_ch.ready;

   rrss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   assign req_ch.ready = req_ready;

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = IDX_W'(index_ff);
      mem_wr_data = nonzero_slice(slice_ff);
      if (ctrl.do_define && define_ok) begin
         mem_wr_en = 1'b1;
      end else if (ctrl.do_restart) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = '0;
         mem_wr_data = restart_slice;
      end
   end

   rrss_slice_mem #(
      .MAX_TASKS (MAX_TASKS)
   ) u_slice_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (ctrl.mem_read),
      .rd_addr (next_ff),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         action_ff <= req_ch.action;
         index_ff  <= req_ch.task_index;
         slice_ff  <= req_ch.slice_ticks;
      end
   end

   always_comb begin
      cand_in = cand_ff;
      if (ctrl.start_search) begin
         cand_in = CNT_W'(cur_ff) + CNT_W'(1);
      end else if (ctrl.reduce_step) begin
         cand_in = cand_ff - rot_n;
      end else if (ctrl.search_adv) begin
         cand_in = (cand_inc == rot_n) ? '0 : cand_inc;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      if (ctrl.start_search) begin
         step_ff <= CNT_W'(1);
      end else if (ctrl.search_adv) begin
         step_ff <= step_ff + CNT_W'(1);
      end
      if (ctrl.take_cand) begin
         next_ff <= cand_ff[IDX_W-1:0];
      end else if (ctrl.take_zero) begin
         next_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         remain_ff <= RESET_SLICE_ZERO;
         active_ff <= {{(MAX_TASKS-1){1'b0}}, 1'b1};
         sw_ff     <= 1'b0;
      end else begin
         if (ctrl.accept) begin
            sw_ff <= 1'b0;
         end
         if (ctrl.do_define && define_ok) begin
            active_ff[IDX_W'(index_ff)] <= 1'b1;
         end
         if (ctrl.do_restart) begin
            active_ff <= {{(MAX_TASKS-1){1'b0}}, 1'b1};
            cur_ff    <= '0;
            remain_ff <= restart_slice;
         end
         if (ctrl.do_tick_dec) begin
            remain_ff <= remain_ff - SLICE_W'(1);
         end
         if (ctrl.load_slice) begin
            cur_ff    <= next_ff;
            remain_ff <= mem_rd_data;
            sw_ff     <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_switched_ff <= sw_ff;
         rsp_task_ff     <= TASK_IDX_W'(cur_ff);
         rsp_ticks_ff    <= remain_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.switched     = rsp_switched_ff;
   assign rsp_ch.running_task = rsp_task_ff;
   assign rsp_ch.ticks_left   = rsp_ticks_ff;

   a_current_active: assert property (@(posedge clock) disable iff (reset)
      active_ff[cur_ff])
      else $error("current task is not marked active");

   a_switch_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_switched_ff |-> rsp_ticks_ff != '0)
      else $error("switch reported with an empty slice");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> !req_ready && !ctrl.emit)
      else $error("scheduler ready again right after a beat");

endmodule

`default_nettype wire

// ----- design/rrss_slice_mem.sv -----
`default_nettype none

module rrss_slice_mem import rrss_pkg::*; #(
   parameter int MAX_TASKS = DEFAULT_MAX_TASKS,
   localparam int IDX_W = $clog2(MAX_TASKS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire logic [SLICE_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output logic      [SLICE_W-1:0] rd_data
);

   logic [SLICE_W-1:0]   mem [MAX_TASKS];
   logic [MAX_TASKS-1:0] valid_ff;
   logic [SLICE_W-1:0]   mem_rd_ff;
   logic                 rd_valid_ff;
   logic                 rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_zero_ff  <= (rd_addr == '0);
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_data = mem_rd_ff;
      end else if (rd_zero_ff) begin
         rd_data = RESET_SLICE_ZERO;
      end else begin
         rd_data = RESET_SLICE_REST;
      end
   end

endmodule

`default_nettype wire

// ----- design/rrss_ctrl.sv -----
`default_nettype none

module rrss_ctrl import rrss_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type status,
   output logic            req_ready,
   output ctrl_type        ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.action == ACT_TICK && status.expires) begin
               state_in = ST_REDUCE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_REDUCE: begin
            if (!status.cand_ge_n) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.cand_active || status.search_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            ctrl.accept = req_valid;
         end
         ST_DECODE: begin
            ctrl.do_define    = (status.action == ACT_DEFINE);
            ctrl.do_restart   = (status.action == ACT_RESTART);
            ctrl.do_tick_dec  = (status.action == ACT_TICK) && !status.expires;
            ctrl.start_search = (status.action == ACT_TICK) && status.expires;
         end
         ST_REDUCE: begin
            ctrl.reduce_step = status.cand_ge_n;
         end
         ST_SEARCH: begin
            ctrl.take_cand  = status.cand_active;
            ctrl.take_zero  = !status.cand_active && status.search_last;
            ctrl.search_adv = !status.cand_active && !status.search_last;
         end
         ST_READ:   ctrl.mem_read = 1'b1;
         ST_LOAD:   ctrl.load_slice = 1'b1;
         ST_FINISH: ctrl.emit = status.out_free;
         default:   ctrl = '0;
      endcase
   end

endmodule

`default_nettype wire
